// ===== hdl/hpi_pkg.sv =====
// hpi_pkg: shared types, constants and fixed-point helpers for the
// hermite particle interpolator; used by every module in hdl/
package hpi_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int POS_WT_FRAC  = 30;
   localparam int DER_WT_FRAC  = 28;
   localparam int DENS_FRAC    = 16;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [2:0] CSR_ALPHA          = 3'd0;
   localparam logic [2:0] CSR_TANGENT_SCALE  = 3'd1;
   localparam logic [2:0] CSR_VEL_UNSCALE    = 3'd2;
   localparam logic [2:0] CSR_STEP_LEFT      = 3'd3;
   localparam logic [2:0] CSR_STEP_RIGHT     = 3'd4;

   localparam logic [16:0]        ALPHA_ONE   = 17'd65536;
   localparam logic signed [31:0] SCALE_ONE   = 32'sd1 <<< FRAC_BITS;
   localparam logic signed [31:0] POS_WT_ONE  = 32'sd1 <<< POS_WT_FRAC;
   localparam logic [32:0]        DENS_HALF   = 33'd1 << (DENS_FRAC - 1);
   localparam logic signed [63:0] S32_MAX     = 64'sd2147483647;
   localparam logic signed [63:0] S32_MIN     = -64'sd2147483648;

   typedef struct packed {
      logic [16:0]        alpha;
      logic signed [31:0] tangent_scale;
      logic signed [31:0] velocity_unscale;
      logic signed [31:0] step_left;
      logic signed [31:0] step_right;
   } cfg_type;

   typedef struct packed {
      logic signed [29:0] g00;
      logic signed [29:0] g10;
      logic signed [29:0] g11;
   } der_wt_type;

   typedef struct packed {
      logic signed [31:0] h00;
      logic signed [31:0] h01;
      logic signed [31:0] h10;
      logic signed [31:0] h11;
   } pos_wt_type;

   typedef struct packed {
      logic signed [31:0] pos_a;
      logic signed [31:0] vel_a;
      logic signed [31:0] pos_b;
      logic signed [31:0] vel_b;
      logic               valid_a;
      logic               valid_b;
      logic [15:0]        density_a;
      logic [15:0]        density_b;
   } item_type;

   typedef struct packed {
      logic signed [31:0] new_pos;
      logic signed [31:0] new_vel;
      logic [15:0]        new_density;
      logic               new_valid;
   } res_type;

   // round half up, then arithmetic shift
   function automatic logic signed [63:0] rshr(input logic signed [63:0] x,
                                               input int unsigned n);
      logic signed [63:0] half;
      half = 64'sd1 <<< (n - 1);
      return (x + half) >>> n;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      if (x > S32_MAX) begin
         return 32'sh7fffffff;
      end else if (x < S32_MIN) begin
         return 32'sh80000000;
      end
      return x[31:0];
   endfunction

endpackage

// ===== hdl/hermite_particle_interpolator_top.sv =====
// hermite_particle_interpolator_top: top level of the particle axis interpolator
// depends on hpi_pkg, hpi_csr, hpi_weights and hpi_datapath
// throughput: one beat per cycle, set by the seven-stage multiply pipeline
// busy stays low; results are strobed by rsp_valid and cannot be stalled
// reset clears all beats in flight and loads the register reset values
module hermite_particle_interpolator_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic signed [31:0]             req_pos_a,
   input  logic signed [31:0]             req_vel_a,
   input  logic signed [31:0]             req_pos_b,
   input  logic signed [31:0]             req_vel_b,
   input  logic                           req_valid_a,
   input  logic                           req_valid_b,
   input  logic [15:0]                    req_density_a,
   input  logic [15:0]                    req_density_b,
   output logic                           rsp_valid,
   output logic signed [31:0]             rsp_new_pos,
   output logic signed [31:0]             rsp_new_vel,
   output logic [15:0]                    rsp_new_density,
   output logic                           rsp_new_valid,
   input  logic                           csr_we,
   input  logic [hpi_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hpi_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import hpi_pkg::*;

   cfg_type    cfg;
   der_wt_type der_wt;
   pos_wt_type pos_wt;
   item_type   item;
   res_type    res;
   logic       accept;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   assign item.pos_a     = req_pos_a;
   assign item.vel_a     = req_vel_a;
   assign item.pos_b     = req_pos_b;
   assign item.vel_b     = req_vel_b;
   assign item.valid_a   = req_valid_a;
   assign item.valid_b   = req_valid_b;
   assign item.density_a = req_density_a;
   assign item.density_b = req_density_b;

   hpi_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   hpi_weights u_weights (
      .clock  (clock),
      .alpha  (cfg.alpha),
      .der_wt (der_wt),
      .pos_wt (pos_wt)
   );

   hpi_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_item   (item),
      .cfg       (cfg),
      .der_wt    (der_wt),
      .pos_wt    (pos_wt),
      .out_valid (rsp_valid),
      .out_res   (res)
   );

   assign rsp_new_pos     = res.new_pos;
   assign rsp_new_vel     = res.new_vel;
   assign rsp_new_density = res.new_density;
   assign rsp_new_valid   = res.new_valid;

endmodule

// ===== hdl/hpi_csr.sv =====
// hpi_csr: configuration registers with the alpha clamp
// depends on hpi_pkg
module hpi_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [hpi_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hpi_pkg::CSR_DATA_W-1:0] csr_wdata,
   output hpi_pkg::cfg_type               cfg
);
   import hpi_pkg::*;

   logic [16:0]        alpha_ff, alpha_in;
   logic signed [31:0] tscale_ff, tscale_in;
   logic signed [31:0] vunscale_ff, vunscale_in;
   logic signed [31:0] step_l_ff, step_l_in;
   logic signed [31:0] step_r_ff, step_r_in;

   always_comb begin
      alpha_in    = alpha_ff;
      tscale_in   = tscale_ff;
      vunscale_in = vunscale_ff;
      step_l_in   = step_l_ff;
      step_r_in   = step_r_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ALPHA:         alpha_in    = csr_wdata[16:0];
            CSR_TANGENT_SCALE: tscale_in   = $signed(csr_wdata);
            CSR_VEL_UNSCALE:   vunscale_in = $signed(csr_wdata);
            CSR_STEP_LEFT:     step_l_in   = $signed(csr_wdata);
            CSR_STEP_RIGHT:    step_r_in   = $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff    <= '0;
         tscale_ff   <= SCALE_ONE;
         vunscale_ff <= SCALE_ONE;
         step_l_ff   <= '0;
         step_r_ff   <= '0;
      end else begin
         alpha_ff    <= alpha_in;
         tscale_ff   <= tscale_in;
         vunscale_ff <= vunscale_in;
         step_l_ff   <= step_l_in;
         step_r_ff   <= step_r_in;
      end
   end

   assign cfg.alpha            = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;
   assign cfg.tangent_scale    = tscale_ff;
   assign cfg.velocity_unscale = vunscale_ff;
   assign cfg.step_left        = step_l_ff;
   assign cfg.step_right       = step_r_ff;

endmodule

// ===== hdl/hpi_weights.sv =====
// hpi_weights: three-stage pipeline forming the hermite basis weights
// and their derivative weights from alpha; depends on hpi_pkg
module hpi_weights (
   input  logic                clock,
   input  logic [16:0]         alpha,
   output hpi_pkg::der_wt_type der_wt,
   output hpi_pkg::pos_wt_type pos_wt
);
   import hpi_pkg::*;

   // stage 1: alpha and its square
   logic [16:0]        a1_ff, a1_in;
   logic [32:0]        sq1_ff, sq1_in;
   logic [33:0]        sq_full;
   // stage 2: cube and derivative weights
   logic [16:0]        a2_ff, a2_in;
   logic [32:0]        sq2_ff, sq2_in;
   logic [48:0]        cube2_ff, cube2_in;
   logic [49:0]        cube_full;
   der_wt_type         der_ff, der_in;
   logic signed [39:0] sq_s, a_s, x00, x10, x11;
   logic signed [39:0] r00, r10, r11;
   // stage 3: position weights
   pos_wt_type         pos_ff, pos_in;
   logic signed [51:0] cube_q, sq_q, a_q, y01, y10, y11;
   logic signed [51:0] q01, q10, q11;

   always_comb begin
      a1_in   = alpha;
      sq_full = {17'b0, alpha} * {17'b0, alpha};
      sq1_in  = sq_full[32:0];
   end

   always_comb begin
      a2_in     = a1_ff;
      sq2_in    = sq1_ff;
      cube_full = {17'b0, sq1_ff} * {33'b0, a1_ff};
      cube2_in  = cube_full[48:0];
      sq_s      = $signed({7'b0, sq1_ff});
      a_s       = $signed({7'b0, a1_ff, 16'b0});
      x00       = (sq_s <<< 2) + (sq_s <<< 1) - ((a_s <<< 2) + (a_s <<< 1));
      x10       = (sq_s <<< 1) + sq_s - (a_s <<< 2) + (40'sd1 <<< 32);
      x11       = (sq_s <<< 1) + sq_s - (a_s <<< 1);
      r00       = (x00 + 40'sd8) >>> 4;
      r10       = (x10 + 40'sd8) >>> 4;
      r11       = (x11 + 40'sd8) >>> 4;
      der_in.g00 = $signed(r00[29:0]);
      der_in.g10 = $signed(r10[29:0]);
      der_in.g11 = $signed(r11[29:0]);
   end

   always_comb begin
      cube_q = $signed({3'b0, cube2_ff});
      sq_q   = $signed({3'b0, sq2_ff, 16'b0});
      a_q    = $signed({3'b0, a2_ff, 32'b0});
      y01    = (sq_q <<< 1) + sq_q - (cube_q <<< 1);
      y10    = cube_q - (sq_q <<< 1) + a_q;
      y11    = cube_q - sq_q;
      q01    = (y01 + (52'sd1 <<< 17)) >>> 18;
      q10    = (y10 + (52'sd1 <<< 17)) >>> 18;
      q11    = (y11 + (52'sd1 <<< 17)) >>> 18;
      pos_in.h01 = $signed(q01[31:0]);
      pos_in.h00 = POS_WT_ONE - $signed(q01[31:0]);
      pos_in.h10 = $signed(q10[31:0]);
      pos_in.h11 = $signed(q11[31:0]);
   end

   always_ff @(posedge clock) begin
      a1_ff    <= a1_in;
      sq1_ff   <= sq1_in;
      a2_ff    <= a2_in;
      sq2_ff   <= sq2_in;
      cube2_ff <= cube2_in;
      der_ff   <= der_in;
      pos_ff   <= pos_in;
   end

   assign der_wt = der_ff;
   assign pos_wt = pos_ff;

endmodule

// ===== hdl/hpi_datapath.sv =====
// hpi_datapath: seven-stage item pipeline for tangents, hermite sums,
// extrapolation and density; depends on hpi_pkg and weights from hpi_weights
module hpi_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  hpi_pkg::item_type   in_item,
   input  hpi_pkg::cfg_type    cfg,
   input  hpi_pkg::der_wt_type der_wt,
   input  hpi_pkg::pos_wt_type pos_wt,
   output logic                out_valid,
   output hpi_pkg::res_type    out_res
);
   import hpi_pkg::*;

   // stage 1
   logic               v1_ff, v1_in, oka1_ff, oka1_in, okb1_ff, okb1_in;
   logic signed [31:0] pa1_ff, pa1_in, pb1_ff, pb1_in, va1_ff, va1_in, vb1_ff, vb1_in;
   logic signed [32:0] diff1_ff, diff1_in;
   logic signed [63:0] tpa1_ff, tpa1_in, tpb1_ff, tpb1_in;
   logic signed [63:0] spa1_ff, spa1_in, spb1_ff, spb1_in;
   logic [31:0]        dpa1_ff, dpa1_in, dpb1_ff, dpb1_in;
   logic [32:0]        dpa_full, dpb_full;
   logic [16:0]        a_inv;
   // stage 2
   logic               v2_ff, v2_in, oka2_ff, oka2_in, okb2_ff, okb2_in;
   logic signed [31:0] pa2_ff, pa2_in, pb2_ff, pb2_in, va2_ff, va2_in, vb2_ff, vb2_in;
   logic signed [32:0] diff2_ff, diff2_in;
   logic signed [31:0] ta2_ff, ta2_in, tb2_ff, tb2_in;
   logic signed [47:0] ea2_ff, ea2_in, eb2_ff, eb2_in;
   logic [15:0]        dens2_ff, dens2_in;
   logic signed [63:0] ea_full, eb_full;
   logic [32:0]        dsum_both, dsum_a, dsum_b;
   // stage 3
   logic               v3_ff, v3_in, oka3_ff, oka3_in, okb3_ff, okb3_in;
   logic signed [31:0] pa3_ff, pa3_in, pb3_ff, pb3_in, ta3_ff, ta3_in, tb3_ff, tb3_in;
   logic signed [31:0] pext3_ff, pext3_in, vcp3_ff, vcp3_in;
   logic signed [63:0] gp00_3_ff, gp00_3_in, gp10_3_ff, gp10_3_in, gp11_3_ff, gp11_3_in;
   logic [15:0]        dens3_ff, dens3_in;
   // stage 4
   logic               v4_ff, v4_in, oka4_ff, oka4_in, okb4_ff, okb4_in;
   logic signed [63:0] hp00_4_ff, hp00_4_in, hp10_4_ff, hp10_4_in;
   logic signed [63:0] hp01_4_ff, hp01_4_in, hp11_4_ff, hp11_4_in;
   logic signed [63:0] dsum4_ff, dsum4_in;
   logic signed [31:0] pext4_ff, pext4_in, vcp4_ff, vcp4_in;
   logic [15:0]        dens4_ff, dens4_in;
   // stage 5
   logic               v5_ff, v5_in, oka5_ff, oka5_in, okb5_ff, okb5_in;
   logic signed [63:0] psum5_ff, psum5_in;
   logic signed [31:0] d5_ff, d5_in, pext5_ff, pext5_in, vcp5_ff, vcp5_in;
   logic [15:0]        dens5_ff, dens5_in;
   // stage 6
   logic               v6_ff, v6_in, oka6_ff, oka6_in, okb6_ff, okb6_in;
   logic signed [31:0] ph6_ff, ph6_in, pext6_ff, pext6_in, vcp6_ff, vcp6_in;
   logic signed [63:0] dp6_ff, dp6_in;
   logic [15:0]        dens6_ff, dens6_in;
   // stage 7, output beat
   logic               v7_ff, v7_in;
   res_type            res7_ff, res7_in;

   always_comb begin
      v1_in    = in_valid;
      oka1_in  = in_item.valid_a;
      okb1_in  = in_item.valid_b;
      pa1_in   = in_item.pos_a;
      pb1_in   = in_item.pos_b;
      va1_in   = in_item.vel_a;
      vb1_in   = in_item.vel_b;
      diff1_in = 33'(in_item.pos_a) - 33'(in_item.pos_b);
      tpa1_in  = 64'(in_item.vel_a) * 64'(cfg.tangent_scale);
      tpb1_in  = 64'(in_item.vel_b) * 64'(cfg.tangent_scale);
      spa1_in  = 64'(in_item.vel_a) * 64'(cfg.step_left);
      spb1_in  = 64'(in_item.vel_b) * 64'(cfg.step_right);
      a_inv    = ALPHA_ONE - cfg.alpha;
      dpa_full = {17'b0, in_item.density_a} * {16'b0, a_inv};
      dpb_full = {17'b0, in_item.density_b} * {16'b0, cfg.alpha};
      dpa1_in  = dpa_full[31:0];
      dpb1_in  = dpb_full[31:0];
   end

   always_comb begin
      v2_in     = v1_ff;
      oka2_in   = oka1_ff;
      okb2_in   = okb1_ff;
      pa2_in    = pa1_ff;
      pb2_in    = pb1_ff;
      va2_in    = va1_ff;
      vb2_in    = vb1_ff;
      diff2_in  = diff1_ff;
      ta2_in    = sat32(rshr(tpa1_ff, FRAC_BITS));
      tb2_in    = sat32(rshr(tpb1_ff, FRAC_BITS));
      ea_full   = rshr(spa1_ff, FRAC_BITS);
      eb_full   = rshr(spb1_ff, FRAC_BITS);
      ea2_in    = $signed(ea_full[47:0]);
      eb2_in    = $signed(eb_full[47:0]);
      dsum_both = {1'b0, dpa1_ff} + {1'b0, dpb1_ff} + DENS_HALF;
      dsum_a    = {1'b0, dpa1_ff} + DENS_HALF;
      dsum_b    = {1'b0, dpb1_ff} + DENS_HALF;
      if (oka1_ff && okb1_ff) begin
         dens2_in = dsum_both[31:16];
      end else if (oka1_ff) begin
         dens2_in = dsum_a[31:16];
      end else if (okb1_ff) begin
         dens2_in = dsum_b[31:16];
      end else begin
         dens2_in = '0;
      end
   end

   always_comb begin
      v3_in     = v2_ff;
      oka3_in   = oka2_ff;
      okb3_in   = okb2_ff;
      pa3_in    = pa2_ff;
      pb3_in    = pb2_ff;
      ta3_in    = ta2_ff;
      tb3_in    = tb2_ff;
      dens3_in  = dens2_ff;
      gp00_3_in = 64'($signed(der_wt.g00)) * 64'(diff2_ff);
      gp10_3_in = 64'($signed(der_wt.g10)) * 64'(ta2_ff);
      gp11_3_in = 64'($signed(der_wt.g11)) * 64'(tb2_ff);
      if (oka2_ff) begin
         pext3_in = sat32(64'(pa2_ff) + 64'(ea2_ff));
         vcp3_in  = va2_ff;
      end else begin
         pext3_in = sat32(64'(pb2_ff) + 64'(eb2_ff));
         vcp3_in  = vb2_ff;
      end
   end

   always_comb begin
      v4_in     = v3_ff;
      oka4_in   = oka3_ff;
      okb4_in   = okb3_ff;
      pext4_in  = pext3_ff;
      vcp4_in   = vcp3_ff;
      dens4_in  = dens3_ff;
      hp00_4_in = 64'($signed(pos_wt.h00)) * 64'(pa3_ff);
      hp10_4_in = 64'($signed(pos_wt.h10)) * 64'(ta3_ff);
      hp01_4_in = 64'($signed(pos_wt.h01)) * 64'(pb3_ff);
      hp11_4_in = 64'($signed(pos_wt.h11)) * 64'(tb3_ff);
      dsum4_in  = gp00_3_ff + gp10_3_ff + gp11_3_ff;
   end

   always_comb begin
      v5_in    = v4_ff;
      oka5_in  = oka4_ff;
      okb5_in  = okb4_ff;
      pext5_in = pext4_ff;
      vcp5_in  = vcp4_ff;
      dens5_in = dens4_ff;
      psum5_in = hp00_4_ff + hp10_4_ff + hp01_4_ff + hp11_4_ff;
      d5_in    = sat32(rshr(dsum4_ff, DER_WT_FRAC));
   end

   always_comb begin
      v6_in    = v5_ff;
      oka6_in  = oka5_ff;
      okb6_in  = okb5_ff;
      pext6_in = pext5_ff;
      vcp6_in  = vcp5_ff;
      dens6_in = dens5_ff;
      ph6_in   = sat32(rshr(psum5_ff, POS_WT_FRAC));
      dp6_in   = 64'(d5_ff) * 64'(cfg.velocity_unscale);
   end

   always_comb begin
      v7_in               = v6_ff;
      res7_in.new_density = dens6_ff;
      res7_in.new_valid   = oka6_ff | okb6_ff;
      if (oka6_ff && okb6_ff) begin
         res7_in.new_pos = ph6_ff;
         res7_in.new_vel = sat32(rshr(dp6_ff, FRAC_BITS));
      end else if (oka6_ff || okb6_ff) begin
         res7_in.new_pos = pext6_ff;
         res7_in.new_vel = vcp6_ff;
      end else begin
         res7_in.new_pos = '0;
         res7_in.new_vel = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v5_in;
         v6_ff <= v6_in;
         v7_ff <= v7_in;
      end
   end

   always_ff @(posedge clock) begin
      oka1_ff   <= oka1_in;
      okb1_ff   <= okb1_in;
      pa1_ff    <= pa1_in;
      pb1_ff    <= pb1_in;
      va1_ff    <= va1_in;
      vb1_ff    <= vb1_in;
      diff1_ff  <= diff1_in;
      tpa1_ff   <= tpa1_in;
      tpb1_ff   <= tpb1_in;
      spa1_ff   <= spa1_in;
      spb1_ff   <= spb1_in;
      dpa1_ff   <= dpa1_in;
      dpb1_ff   <= dpb1_in;

      oka2_ff   <= oka2_in;
      okb2_ff   <= okb2_in;
      pa2_ff    <= pa2_in;
      pb2_ff    <= pb2_in;
      va2_ff    <= va2_in;
      vb2_ff    <= vb2_in;
      diff2_ff  <= diff2_in;
      ta2_ff    <= ta2_in;
      tb2_ff    <= tb2_in;
      ea2_ff    <= ea2_in;
      eb2_ff    <= eb2_in;
      dens2_ff  <= dens2_in;

      oka3_ff   <= oka3_in;
      okb3_ff   <= okb3_in;
      pa3_ff    <= pa3_in;
      pb3_ff    <= pb3_in;
      ta3_ff    <= ta3_in;
      tb3_ff    <= tb3_in;
      pext3_ff  <= pext3_in;
      vcp3_ff   <= vcp3_in;
      gp00_3_ff <= gp00_3_in;
      gp10_3_ff <= gp10_3_in;
      gp11_3_ff <= gp11_3_in;
      dens3_ff  <= dens3_in;

      oka4_ff   <= oka4_in;
      okb4_ff   <= okb4_in;
      hp00_4_ff <= hp00_4_in;
      hp10_4_ff <= hp10_4_in;
      hp01_4_ff <= hp01_4_in;
      hp11_4_ff <= hp11_4_in;
      dsum4_ff  <= dsum4_in;
      pext4_ff  <= pext4_in;
      vcp4_ff   <= vcp4_in;
      dens4_ff  <= dens4_in;

      oka5_ff   <= oka5_in;
      okb5_ff   <= okb5_in;
      psum5_ff  <= psum5_in;
      d5_ff     <= d5_in;
      pext5_ff  <= pext5_in;
      vcp5_ff   <= vcp5_in;
      dens5_ff  <= dens5_in;

      oka6_ff   <= oka6_in;
      okb6_ff   <= okb6_in;
      ph6_ff    <= ph6_in;
      dp6_ff    <= dp6_in;
      pext6_ff  <= pext6_in;
      vcp6_ff   <= vcp6_in;
      dens6_ff  <= dens6_in;

      res7_ff   <= res7_in;
   end

   assign out_valid = v7_ff;
   assign out_res   = res7_ff;

endmodule
